FILE: hdl/ppiu_pkg.sv
// ----------------------------------------------------------------------------
// ppiu_pkg
// Shared constants, types and helper functions of the palette index unpacker.
// ----------------------------------------------------------------------------
package ppiu_pkg;

  localparam int SECTION_ENTRIES = 4096;
  localparam int WORD_BITS       = 64;
  localparam int MAX_FIELD_BITS  = 12;
  localparam int FLUSH_BURST     = 16;

  // Port widths of the item fields.
  localparam int DATA_BITS     = 64;
  localparam int POS_OUT_BITS  = 12;
  localparam int IDX_OUT_BITS  = 12;
  localparam int PAL_BITS      = 13;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_IDX_BITS  = 1;

  localparam int POS_BITS   = $clog2(SECTION_ENTRIES);
  localparam int WID_BITS   = $clog2(MAX_FIELD_BITS + 1);
  localparam int CARRY_BITS = MAX_FIELD_BITS - 1;
  localparam int CNT_BITS   = $clog2(MAX_FIELD_BITS);
  localparam int SR_BITS    = WORD_BITS + CARRY_BITS;
  localparam int LEFT_BITS  = $clog2(SR_BITS + 1);
  localparam int BURST_BITS = (FLUSH_BURST > 1) ? $clog2(FLUSH_BURST) : 1;

  localparam logic [PAL_BITS-1:0] PAL_LIMIT = PAL_BITS'(1 << MAX_FIELD_BITS);

  localparam logic [CFG_IDX_BITS-1:0] REG_PALETTE_SIZE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPANNING     = 1'b1;

  // Command codes of an input item.
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [PAL_BITS-1:0]       pal_eff;
    logic [WID_BITS-1:0]       width;
    logic [MAX_FIELD_BITS-1:0] mask;
    logic                      spanning;
    logic                      active;
  } cfg_t;

  // Bit length of (p - 1), at least four; p is already clamped.
  function automatic logic [WID_BITS-1:0] field_width(input logic [PAL_BITS-1:0] p);
    logic [PAL_BITS-1:0] pm1;
    logic [WID_BITS-1:0] b;
    pm1 = p - 1'b1;
    b   = WID_BITS'(4);
    if (p > PAL_BITS'(1)) begin
      for (int i = 4; i < MAX_FIELD_BITS; i++) begin
        if (pm1[i]) begin
          b = WID_BITS'(i + 1);
        end
      end
    end
    return b;
  endfunction

  function automatic logic [MAX_FIELD_BITS-1:0] field_mask(input logic [WID_BITS-1:0] w);
    logic [MAX_FIELD_BITS:0] m;
    m = ((MAX_FIELD_BITS + 1)'(1) << w) - 1'b1;
    return m[MAX_FIELD_BITS-1:0];
  endfunction

endpackage

FILE: hdl/packed_palette_index_unpacker_unit.sv
// ----------------------------------------------------------------------------
// packed_palette_index_unpacker_unit
// Unpacks the palette indices of one section from packed data words.
// ----------------------------------------------------------------------------
// Input items carry a command bit and a 64-bit data word. A data word is
// loaded, together with any bits carried over from the previous word, into a
// shift register that gives one field per cycle unless the receiver stalls; a
// flush gives the pending carried field, if any, and then zeros, up to sixteen
// results. Each result item carries the block position, the decoded index, a
// last flag on the final result of its input item and a flag on position 4095.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user
// must write it only while idle, which the block itself does not enforce.
// A data word of field width w yields floor((c + 64) / w) results (c carried
// bits), fewer only when the section ends inside the word; 16 fields at width
// four. A data word with a palette of one entry or none is taken and gives no
// result. An accepted item moves the unit to its data or flush state, from
// which each result is registered into the output register. A new item is
// accepted as soon as the previous one has put its last result into the
// output register, while that result still waits.
// A stalled receiver holds the output register and pauses the shift register.
// Reset clears the position, the carried bits and the registers (palette size
// 0, packed layout); no clearing pass is needed.
// ----------------------------------------------------------------------------
module packed_palette_index_unpacker_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [ppiu_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ppiu_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic [ppiu_pkg::DATA_BITS-1:0]       in_data_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ppiu_pkg::POS_OUT_BITS-1:0]    out_position,
  output logic [ppiu_pkg::IDX_OUT_BITS-1:0]    out_palette_index,
  output logic                                 out_last,
  output logic                                 out_section_done
);

  ppiu_pkg::cfg_t cfg;

  ppiu_pkg::state_t state_r, state_nxt;
  logic [ppiu_pkg::POS_BITS-1:0]     pos_r, pos_nxt;
  logic [ppiu_pkg::CARRY_BITS-1:0]   carry_r, carry_nxt;
  logic [ppiu_pkg::CNT_BITS-1:0]     carry_cnt_r, carry_cnt_nxt;
  logic                              flush_carry_r, flush_carry_nxt;
  logic [ppiu_pkg::BURST_BITS-1:0]   burst_r, burst_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [ppiu_pkg::POS_OUT_BITS-1:0]   out_position_r, out_position_nxt;
  logic [ppiu_pkg::IDX_OUT_BITS-1:0]   out_palette_index_r, out_palette_index_nxt;
  logic                                out_last_r, out_last_nxt;
  logic                                out_section_done_r, out_section_done_nxt;

  logic                                    load, shift, emit_go, done, last;
  logic [ppiu_pkg::CNT_BITS-1:0]           load_shamt;
  logic [ppiu_pkg::CARRY_BITS:0]           low_mask;
  logic [ppiu_pkg::CARRY_BITS-1:0]         load_low;
  logic [ppiu_pkg::MAX_FIELD_BITS-1:0]     digit, value;
  logic [ppiu_pkg::CARRY_BITS-1:0]         rest;
  logic [ppiu_pkg::LEFT_BITS-1:0]          bits_left;
  logic [ppiu_pkg::LEFT_BITS-1:0]          two_fields;

  ppiu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ppiu_shift u_shift (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_word  (in_data_word[ppiu_pkg::WORD_BITS-1:0]),
    .load_shamt (load_shamt),
    .load_low   (load_low),
    .shift      (shift),
    .width      (cfg.width),
    .digit      (digit),
    .rest       (rest),
    .bits_left  (bits_left)
  );

  // Carried bits only join the next word when they are narrower than a field.
  always_comb begin
    load_shamt = (cfg.spanning && (carry_cnt_r < ppiu_pkg::CNT_BITS'(cfg.width)))
               ? carry_cnt_r : '0;
    low_mask   = ((ppiu_pkg::CARRY_BITS + 1)'(1) << load_shamt) - 1'b1;
    load_low   = carry_r & low_mask[ppiu_pkg::CARRY_BITS-1:0];
  end

  assign in_ready   = (state_r == ppiu_pkg::ST_IDLE);
  assign emit_go    = (state_r != ppiu_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign done       = (pos_r == ppiu_pkg::POS_BITS'(ppiu_pkg::SECTION_ENTRIES - 1));
  assign two_fields = ppiu_pkg::LEFT_BITS'({cfg.width, 1'b0});

  always_comb begin
    state_nxt             = state_r;
    pos_nxt               = pos_r;
    carry_nxt             = carry_r;
    carry_cnt_nxt         = carry_cnt_r;
    flush_carry_nxt       = flush_carry_r;
    burst_nxt             = burst_r;
    out_valid_nxt         = out_valid_r && !out_ready;
    out_position_nxt      = out_position_r;
    out_palette_index_nxt = out_palette_index_r;
    out_last_nxt          = out_last_r;
    out_section_done_nxt  = out_section_done_r;
    load                  = 1'b0;
    shift                 = 1'b0;
    value                 = '0;
    last                  = 1'b0;

    unique case (state_r)
      ppiu_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_command == ppiu_pkg::CMD_FLUSH) begin
            flush_carry_nxt = cfg.spanning && (carry_cnt_r != '0);
            burst_nxt       = '0;
            state_nxt       = ppiu_pkg::ST_FLUSH;
          end else if (cfg.active) begin
            load      = 1'b1;
            state_nxt = ppiu_pkg::ST_DATA;
          end
        end
      end
      ppiu_pkg::ST_DATA: begin
        value = digit & cfg.mask;
        last  = done || (bits_left < two_fields);
        if (emit_go) begin
          shift = 1'b1;
          if (done) begin
            carry_nxt     = '0;
            carry_cnt_nxt = '0;
          end else if (last) begin
            carry_nxt     = cfg.spanning ? rest : '0;
            carry_cnt_nxt = cfg.spanning
                          ? ppiu_pkg::CNT_BITS'(bits_left - ppiu_pkg::LEFT_BITS'(cfg.width))
                          : '0;
          end
        end
      end
      ppiu_pkg::ST_FLUSH: begin
        // A straddling field goes out with only its low bits.
        value = flush_carry_r
              ? (ppiu_pkg::MAX_FIELD_BITS'(carry_r) & cfg.mask) : '0;
        last  = done || (burst_r == ppiu_pkg::BURST_BITS'(ppiu_pkg::FLUSH_BURST - 1));
        if (emit_go) begin
          flush_carry_nxt = 1'b0;
          carry_nxt       = '0;
          carry_cnt_nxt   = '0;
          burst_nxt       = burst_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ppiu_pkg::ST_IDLE;
      end
    endcase

    if (emit_go) begin
      out_valid_nxt         = 1'b1;
      out_position_nxt      = ppiu_pkg::POS_OUT_BITS'(pos_r);
      out_palette_index_nxt = (ppiu_pkg::PAL_BITS'(value) < cfg.pal_eff)
                            ? ppiu_pkg::IDX_OUT_BITS'(value) : '0;
      out_last_nxt          = last;
      out_section_done_nxt  = done;
      pos_nxt               = done ? '0 : pos_r + 1'b1;
      if (last) begin
        state_nxt = ppiu_pkg::ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ppiu_pkg::ST_IDLE;
      pos_r         <= '0;
      carry_r       <= '0;
      carry_cnt_r   <= '0;
      flush_carry_r <= 1'b0;
      burst_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      carry_r       <= carry_nxt;
      carry_cnt_r   <= carry_cnt_nxt;
      flush_carry_r <= flush_carry_nxt;
      burst_r       <= burst_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_position_r      <= out_position_nxt;
    out_palette_index_r <= out_palette_index_nxt;
    out_last_r          <= out_last_nxt;
    out_section_done_r  <= out_section_done_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_position      = out_position_r;
  assign out_palette_index = out_palette_index_r;
  assign out_last          = out_last_r;
  assign out_section_done  = out_section_done_r;

  // While a word is being unpacked, the shift register holds a whole field.
  a_field_available: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppiu_pkg::ST_DATA) |-> (bits_left >= ppiu_pkg::LEFT_BITS'(cfg.width)))
    else $error("shift register ran short of a field");

  // The end of a section brings the position back to the start.
  a_section_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && done) |=> (pos_r == '0) && (carry_cnt_r == '0))
    else $error("state not cleared after section end");

  // The last result of an item frees the input side.
  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && last) |=> in_ready && out_valid && out_last)
    else $error("input not released after last result");

endmodule

FILE: hdl/ppiu_cfg.sv
// ----------------------------------------------------------------------------
// ppiu_cfg
// Configuration registers with the field width and mask decoded at write time.
// ----------------------------------------------------------------------------
module ppiu_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [ppiu_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ppiu_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  output ppiu_pkg::cfg_t                       cfg
);

  ppiu_pkg::cfg_t cfg_r, cfg_nxt;
  logic [ppiu_pkg::PAL_BITS-1:0] pal_clamped;

  always_comb begin
    pal_clamped = (cfg_wdata > ppiu_pkg::PAL_LIMIT) ? ppiu_pkg::PAL_LIMIT : cfg_wdata;
    cfg_nxt     = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        ppiu_pkg::REG_PALETTE_SIZE: begin
          cfg_nxt.pal_eff = pal_clamped;
          cfg_nxt.width   = ppiu_pkg::field_width(pal_clamped);
          cfg_nxt.mask    = ppiu_pkg::field_mask(ppiu_pkg::field_width(pal_clamped));
          cfg_nxt.active  = pal_clamped > ppiu_pkg::PAL_BITS'(1);
        end
        ppiu_pkg::REG_SPANNING: begin
          cfg_nxt.spanning = cfg_wdata[0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pal_eff  <= '0;
      cfg_r.width    <= ppiu_pkg::WID_BITS'(4);
      cfg_r.mask     <= ppiu_pkg::field_mask(ppiu_pkg::WID_BITS'(4));
      cfg_r.spanning <= 1'b0;
      cfg_r.active   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/ppiu_shift.sv
// ----------------------------------------------------------------------------
// ppiu_shift
// Field shift register: holds the carried bits below a data word and hands
// out one field per cycle from its low end while shift is asserted.
// ----------------------------------------------------------------------------
module ppiu_shift (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic [ppiu_pkg::WORD_BITS-1:0]        load_word,
  input  logic [ppiu_pkg::CNT_BITS-1:0]         load_shamt,
  input  logic [ppiu_pkg::CARRY_BITS-1:0]       load_low,
  input  logic                                  shift,
  input  logic [ppiu_pkg::WID_BITS-1:0]         width,
  output logic [ppiu_pkg::MAX_FIELD_BITS-1:0]   digit,
  output logic [ppiu_pkg::CARRY_BITS-1:0]       rest,
  output logic [ppiu_pkg::LEFT_BITS-1:0]        bits_left
);

  logic [ppiu_pkg::SR_BITS-1:0]   sr_r, sr_nxt, sr_shifted;
  logic [ppiu_pkg::LEFT_BITS-1:0] left_r, left_nxt;

  always_comb begin
    sr_shifted = sr_r >> width;
    sr_nxt     = sr_r;
    left_nxt   = left_r;
    if (load) begin
      sr_nxt   = (ppiu_pkg::SR_BITS'(load_word) << load_shamt)
               | ppiu_pkg::SR_BITS'(load_low);
      left_nxt = ppiu_pkg::LEFT_BITS'(ppiu_pkg::WORD_BITS)
               + ppiu_pkg::LEFT_BITS'(load_shamt);
    end else if (shift) begin
      sr_nxt   = sr_shifted;
      left_nxt = left_r - ppiu_pkg::LEFT_BITS'(width);
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  assign digit     = sr_r[ppiu_pkg::MAX_FIELD_BITS-1:0];
  assign rest      = sr_shifted[ppiu_pkg::CARRY_BITS-1:0];
  assign bits_left = left_r;

endmodule
